/* design/nbm_pkg.sv */
// Shared constants, types and helpers for the nested bracket matcher.
package nbm_pkg;

	localparam int STACK_DEPTH   = 64;
	localparam int POSITION_BITS = 20;
	localparam int NUM_KINDS     = 7;
	localparam int BAL_W         = 21;
	localparam int ADDR_W        = $clog2(STACK_DEPTH);
	localparam int FILL_W        = $clog2(STACK_DEPTH + 1);

	typedef logic [3:0]               kind_t;
	typedef logic [2:0]               kidx_t;
	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic signed [BAL_W-1:0]  bal_t;
	typedef logic [FILL_W-1:0]        fill_t;

	localparam kind_t KIND_OTHER     = 4'd0;
	localparam kind_t KIND_FMT_DELIM = 4'd15;

	localparam bal_t BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
	localparam bal_t BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNCLOSED  = 3'd1,
		ST_MISMATCH  = 3'd2,
		ST_STRAY     = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef struct packed {
		kidx_t kidx;
		pos_t  pos;
	} entry_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		logic   clear;
		entry_t entry;
	} stack_cmd_t;

	typedef struct packed {
		fill_t  fill;
		entry_t top;
		entry_t below;
	} stack_stat_t;

	// Mask bit of a kind index: fmt_delim sits at bit 3.
	function automatic logic [2:0] mask_bit(input kidx_t idx);
		logic [2:0] b;
		b = (idx < 3'd3) ? idx : idx + 3'd1;
		return b;
	endfunction

endpackage

/* design/nbm_tok_if.sv */
// Token request channel: valid/ready handshake with token payload.
interface nbm_tok_if;
	logic                valid;
	logic                ready;
	nbm_pkg::kind_t      token_kind;
	logic                last_token;

	modport source (output valid, output token_kind, output last_token, input ready);
	modport sink   (input valid, input token_kind, input last_token, output ready);
endinterface

/* design/nbm_res_if.sv */
// Result request channel: valid/ready handshake with check result payload.
interface nbm_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [19:0] error_position;
	logic [3:0]  error_token;
	logic [7:0]  missing_closer_mask;
	logic [7:0]  missing_opener_mask;

	modport source (output valid, output status, output error_position, output error_token,
		output missing_closer_mask, output missing_opener_mask, input ready);
	modport sink   (input valid, input status, input error_position, input error_token,
		input missing_closer_mask, input missing_opener_mask, output ready);
endinterface

/* design/nbm_stack.sv */
// Opener stack: memory plus registered top entry and prefetched entry below it.
module nbm_stack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nbm_pkg::stack_cmd_t  cmd,
	output nbm_pkg::stack_stat_t stat
);
	import nbm_pkg::*;

	entry_t            mem [STACK_DEPTH];
	fill_t             fill_q;
	fill_t             fill_n;
	entry_t            top_q;
	entry_t            below_q;
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		if (cmd.clear) begin
			fill_n = '0;
		end else if (cmd.push) begin
			fill_n = fill_q + fill_t'(1);
		end else if (cmd.pop) begin
			fill_n = fill_q - fill_t'(1);
		end else begin
			fill_n = fill_q;
		end
		rd_addr = ADDR_W'(fill_n - fill_t'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[fill_q[ADDR_W-1:0]] <= cmd.entry;
		end
		below_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= cmd.entry;
		end else if (cmd.pop) begin
			top_q <= below_q;
		end
	end

	assign stat.fill  = fill_q;
	assign stat.top   = top_q;
	assign stat.below = below_q;

endmodule

/* design/nested_bracket_matcher_unit.sv */
// The result is registered when a last token advances from the input stage.
// Throughput: one token per cycle when not stalled; the stack keeps its top entry
// in a register and prefetches the entry below it from memory every cycle.
// The input stage stalls only while a last token waits on a full result register.
// Reset clears stack fill, token index, balances, parity and the latched error;
// the same state is restored after every last token.
module nested_bracket_matcher_unit (
	input  logic      clk,
	input  logic      arst_n,
	nbm_tok_if.sink   tok,
	nbm_res_if.source res
);
	import nbm_pkg::*;

	logic        valid_s1;
	kind_t       kind_s1;
	logic        last_s1;
	logic        adv;
	logic        go;

	pos_t        idx_q;
	bal_t        bal_q [NUM_KINDS];
	bal_t        bal_n [NUM_KINDS];
	logic        parity_q;
	logic        parity_n;
	status_t     err_st_q;
	pos_t        err_pos_q;
	kind_t       err_tok_q;
	status_t     err_st_n;
	pos_t        err_pos_n;
	kind_t       err_tok_n;

	stack_cmd_t  cmd;
	stack_stat_t stat;

	logic        is_bracket;
	logic        opener;
	kidx_t       kidx;
	logic        err_free;
	logic        full;
	logic        empty;
	fill_t       fill_after;
	entry_t      top_after;

	status_t     fin_st;
	pos_t        fin_pos;
	kind_t       fin_tok;
	logic [7:0]  mc;
	logic [7:0]  mo;

	logic        res_valid_q;

	nbm_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign adv       = !last_s1 || !res_valid_q || res.ready;
	assign tok.ready = !valid_s1 || adv;
	assign go        = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tok.valid && tok.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok.valid && tok.ready) begin
			kind_s1 <= tok.token_kind;
			last_s1 <= tok.last_token;
		end
	end

	always_comb begin
		is_bracket = (kind_s1 != KIND_OTHER) && (kind_s1 != KIND_FMT_DELIM);
		opener     = kind_s1[0];
		kidx       = opener ? kind_s1[3:1] : kind_s1[3:1] - 3'd1;
		err_free   = (err_st_q == ST_OK);
		full       = (stat.fill == fill_t'(STACK_DEPTH));
		empty      = (stat.fill == '0);

		cmd.push        = go && is_bracket && err_free && opener && !full;
		cmd.pop         = go && is_bracket && err_free && !opener && !empty
			&& (stat.top.kidx == kidx);
		cmd.clear       = go && last_s1;
		cmd.entry.kidx  = kidx;
		cmd.entry.pos   = idx_q;

		err_st_n  = err_st_q;
		err_pos_n = err_pos_q;
		err_tok_n = err_tok_q;
		if (is_bracket && err_free) begin
			if (opener) begin
				if (full) begin
					err_st_n  = ST_OVERFLOW;
					err_pos_n = idx_q;
					err_tok_n = kind_s1;
				end
			end else if (empty) begin
				err_st_n  = ST_STRAY;
				err_pos_n = '0;
				err_tok_n = kind_s1;
			end else if (stat.top.kidx != kidx) begin
				err_st_n  = ST_MISMATCH;
				err_pos_n = idx_q;
				err_tok_n = kind_s1;
			end
		end

		fill_after = stat.fill;
		top_after  = stat.top;
		if (cmd.push) begin
			fill_after = stat.fill + fill_t'(1);
			top_after  = cmd.entry;
		end else if (cmd.pop) begin
			fill_after = stat.fill - fill_t'(1);
			top_after  = stat.below;
		end

		for (int i = 0; i < NUM_KINDS; i++) begin
			bal_n[i] = bal_q[i];
			if (is_bracket && (kidx == kidx_t'(i))) begin
				if (opener) begin
					if (bal_q[i] != BAL_MAX) bal_n[i] = bal_q[i] + bal_t'(1);
				end else begin
					if (bal_q[i] != BAL_MIN) bal_n[i] = bal_q[i] - bal_t'(1);
				end
			end
		end
		parity_n = parity_q ^ (kind_s1 == KIND_FMT_DELIM);

		fin_st  = err_st_n;
		fin_pos = err_pos_n;
		fin_tok = err_tok_n;
		if ((err_st_n == ST_OK) && (fill_after != '0)) begin
			fin_st  = ST_UNCLOSED;
			fin_pos = top_after.pos;
			fin_tok = {top_after.kidx, 1'b1};
		end

		mc = '0;
		mo = '0;
		if (fin_st != ST_OK) begin
			for (int i = 0; i < NUM_KINDS; i++) begin
				if (bal_n[i] > 0) mc[mask_bit(kidx_t'(i))] = 1'b1;
				if (bal_n[i] < 0) mo[mask_bit(kidx_t'(i))] = 1'b1;
			end
			if (parity_n) mc[3] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			parity_q  <= 1'b0;
			err_st_q  <= ST_OK;
			err_pos_q <= '0;
			err_tok_q <= '0;
			for (int i = 0; i < NUM_KINDS; i++) bal_q[i] <= '0;
		end else if (go) begin
			if (last_s1) begin
				idx_q     <= '0;
				parity_q  <= 1'b0;
				err_st_q  <= ST_OK;
				err_pos_q <= '0;
				err_tok_q <= '0;
				for (int i = 0; i < NUM_KINDS; i++) bal_q[i] <= '0;
			end else begin
				idx_q     <= idx_q + pos_t'(1);
				parity_q  <= parity_n;
				err_st_q  <= err_st_n;
				err_pos_q <= err_pos_n;
				err_tok_q <= err_tok_n;
				for (int i = 0; i < NUM_KINDS; i++) bal_q[i] <= bal_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (go && last_s1) || (res_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			res.status              <= fin_st;
			res.error_position      <= 20'(fin_pos);
			res.error_token         <= fin_tok;
			res.missing_closer_mask <= mc;
			res.missing_opener_mask <= mo;
		end
	end

	assign res.valid = res_valid_q;

endmodule
